FILE: rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared constants and types of the servo channel frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 16;
  localparam int CH_IDX_W    = 4;
  localparam int POS_W       = 6;

  // frame layout
  localparam int STORE_DEPTH   = 14;
  localparam int CHANNEL_COUNT = 14;
  localparam int POS_CSUM_LO   = 30;
  localparam int POS_CSUM_HI   = 31;

  localparam logic [BYTE_W-1:0] LEN_BYTE = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_BYTE = 8'h40;
  localparam logic [SUM_W-1:0]  SUM_INIT = 16'hFFFF;

  // control word for the checksum unit
  typedef struct packed {
    logic              load;     // restart from the initial sum
    logic              sub;      // subtract the operand this cycle
    logic [BYTE_W-1:0] operand;
  } sum_ctrl_t;

endpackage

FILE: rtl/scfp_byte_if.sv
// ----------------------------------------------------------------------------
// scfp_byte_if
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
interface scfp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [scfp_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/scfp_chan_if.sv
// ----------------------------------------------------------------------------
// scfp_chan_if
// Valid/ready channel carrying one decoded channel value per item.
// ----------------------------------------------------------------------------
interface scfp_chan_if;
  logic                          valid;
  logic                          ready;
  logic [scfp_pkg::CH_IDX_W-1:0] channel_index;
  logic [scfp_pkg::SUM_W-1:0]    channel_value;
  logic                          last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

FILE: rtl/scfp_checksum.sv
// ----------------------------------------------------------------------------
// scfp_checksum
// Running frame checksum: one shared subtractor plus an equality compare.
// ----------------------------------------------------------------------------
module scfp_checksum (
  input  logic                        clk,
  input  logic                        rst,
  input  scfp_pkg::sum_ctrl_t         ctrl,
  input  logic [scfp_pkg::SUM_W-1:0]  check_word,
  output logic                        match
);

  logic [scfp_pkg::SUM_W-1:0] running_sum;
  logic [scfp_pkg::SUM_W-1:0] running_sum_next;
  logic [scfp_pkg::SUM_W-1:0] base;
  logic [scfp_pkg::SUM_W-1:0] subtrahend;

  always_comb begin
    base       = ctrl.load ? scfp_pkg::SUM_INIT : running_sum;
    subtrahend = ctrl.sub ? {{(scfp_pkg::SUM_W-scfp_pkg::BYTE_W){1'b0}}, ctrl.operand}
                          : '0;
    running_sum_next = base - subtrahend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= scfp_pkg::SUM_INIT;
    end else if (ctrl.load || ctrl.sub) begin
      running_sum <= running_sum_next;
    end
  end

  assign match = (check_word == running_sum);

endmodule

FILE: rtl/servo_channel_frame_parser.sv
// ----------------------------------------------------------------------------
// servo_channel_frame_parser
// Receive-side parser for 32-byte, 14-channel servo frames.
// ----------------------------------------------------------------------------
// byte_in takes one serial byte per item. The parser hunts for the length
// byte, expects the command byte next, then gathers 28 payload bytes into a
// 14-entry channel store and 2 checksum bytes. The checksum is kept by a
// single subtractor, one byte per cycle while the parser is receiving.
// When the second checksum byte matches, chan_out delivers the channels as
// a run of CHANNEL_COUNT items, index 0 first, last_channel set on the final
// one. The state register moves to emitting on the checksum byte, and the
// first item is then loaded into the output register; after that one item
// per cycle while chan_out.ready is high. byte_in.ready is low until the
// final item of the run has been loaded into the output register.
// A stall on chan_out holds the current item and pauses the run.
// A failed frame yields nothing and hunting restarts.
// Reset (synchronous, active high) returns to hunting and clears the output
// valid; the channel store is not cleared.
// ----------------------------------------------------------------------------
module servo_channel_frame_parser (
  input  logic       clk,
  input  logic       rst,
  scfp_byte_if.sink  byte_in,
  scfp_chan_if.source chan_out
);

  localparam logic ST_RECV = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                            state;
  logic [scfp_pkg::POS_W-1:0]      frame_position;
  logic [scfp_pkg::BYTE_W-1:0]     low_byte_hold;
  logic [scfp_pkg::CH_IDX_W-1:0]   emit_index;
  logic [scfp_pkg::SUM_W-1:0]      channel_store [scfp_pkg::STORE_DEPTH];

  logic                            out_valid;
  logic [scfp_pkg::CH_IDX_W-1:0]   out_index;
  logic [scfp_pkg::SUM_W-1:0]      out_value;
  logic                            out_last;

  scfp_pkg::sum_ctrl_t             sum_ctrl;
  logic                            sum_match;
  logic                            take;
  logic                            load_out;
  logic                            emit_last;
  logic [scfp_pkg::BYTE_W-1:0]     b;
  logic [scfp_pkg::CH_IDX_W-1:0]   wr_index;
  logic                            in_payload;

  assign byte_in.ready = (state == ST_RECV);
  assign take          = byte_in.valid && byte_in.ready;
  assign b             = byte_in.data_byte;
  assign load_out      = (state == ST_EMIT) && (!out_valid || chan_out.ready);
  assign emit_last     = (emit_index == scfp_pkg::CH_IDX_W'(scfp_pkg::CHANNEL_COUNT - 1));
  assign in_payload    = (frame_position >= scfp_pkg::POS_W'(2)) &&
                         (frame_position <  scfp_pkg::POS_W'(scfp_pkg::POS_CSUM_LO));
  // store slot for an odd payload position: (pos - 2) / 2
  assign wr_index      = frame_position[4:1] - scfp_pkg::CH_IDX_W'(1);

  always_comb begin
    sum_ctrl.load    = 1'b0;
    sum_ctrl.sub     = 1'b0;
    sum_ctrl.operand = b;
    if (take) begin
      if (frame_position == '0) begin
        sum_ctrl.load = (b == scfp_pkg::LEN_BYTE);
        sum_ctrl.sub  = (b == scfp_pkg::LEN_BYTE);
      end else if (frame_position == scfp_pkg::POS_W'(1)) begin
        sum_ctrl.sub  = (b == scfp_pkg::CMD_BYTE);
      end else if (in_payload) begin
        sum_ctrl.sub  = 1'b1;
      end
    end
  end

  scfp_checksum u_checksum (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sum_ctrl),
    .check_word ({b, low_byte_hold}),
    .match      (sum_match)
  );

  // frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RECV;
      frame_position <= '0;
      low_byte_hold  <= '0;
      emit_index     <= '0;
    end else begin
      unique case (state)
        ST_RECV: begin
          if (take) begin
            if (frame_position == '0) begin
              if (b == scfp_pkg::LEN_BYTE) frame_position <= scfp_pkg::POS_W'(1);
            end else if (frame_position == scfp_pkg::POS_W'(1)) begin
              // a wrong command byte is dropped, not rechecked as a length byte
              frame_position <= (b == scfp_pkg::CMD_BYTE) ? scfp_pkg::POS_W'(2) : '0;
            end else if (in_payload) begin
              if (!frame_position[0]) low_byte_hold <= b;
              frame_position <= frame_position + scfp_pkg::POS_W'(1);
            end else if (frame_position == scfp_pkg::POS_W'(scfp_pkg::POS_CSUM_LO)) begin
              low_byte_hold  <= b;
              frame_position <= scfp_pkg::POS_W'(scfp_pkg::POS_CSUM_HI);
            end else begin
              frame_position <= '0;
              if (sum_match) begin
                state      <= ST_EMIT;
                emit_index <= '0;
              end
            end
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            if (emit_last) begin
              state <= ST_RECV;
            end else begin
              emit_index <= emit_index + scfp_pkg::CH_IDX_W'(1);
            end
          end
        end
        default: state <= ST_RECV;
      endcase
    end
  end

  // channel store, written on the high byte of each pair
  always_ff @(posedge clk) begin
    if (take && in_payload && frame_position[0]) begin
      channel_store[wr_index] <= {b, low_byte_hold};
    end
  end

  // output register, loaded straight from the store
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (chan_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= channel_store[emit_index];
      out_index <= emit_index;
      out_last  <= emit_last;
    end
  end

  assign chan_out.valid         = out_valid;
  assign chan_out.channel_index = out_index;
  assign chan_out.channel_value = out_value;
  assign chan_out.last_channel  = out_last;

endmodule

FILE: rtl/scfp_checker.sv
// ----------------------------------------------------------------------------
// scfp_checker
// Port-level checks on the frame parser's output run, bound to the top level.
// ----------------------------------------------------------------------------
module scfp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [scfp_pkg::CH_IDX_W-1:0] out_index,
  input  logic [scfp_pkg::SUM_W-1:0]    out_value,
  input  logic                          out_last
);

  // a pending item holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) &&
                                $stable(out_value) && $stable(out_last))
    else $error("stalled output item changed");

  // inside a run the next item follows at once with the next index
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_index == $past(out_index) + scfp_pkg::CH_IDX_W'(1)))
    else $error("channel run broken or out of order");

  // the run ends on the final channel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |->
      out_index == scfp_pkg::CH_IDX_W'(scfp_pkg::CHANNEL_COUNT - 1))
    else $error("last marker on wrong channel");

  // no byte is taken while a run is still being emitted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("byte input ready during channel run");

endmodule

bind servo_channel_frame_parser scfp_checker u_scfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (byte_in.ready),
  .out_valid (chan_out.valid),
  .out_ready (chan_out.ready),
  .out_index (chan_out.channel_index),
  .out_value (chan_out.channel_value),
  .out_last  (chan_out.last_channel)
);

FILE: test/scfp_channel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_channel_checker
// Follows the serial bytes that the parser accepts, works out the channel
// items that each verified frame must produce and compares them, in order,
// with the items taken from the parser's output.
// ----------------------------------------------------------------------------
module scfp_channel_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  input  logic                          byte_ready,
  input  logic [scfp_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          chan_valid,
  input  logic                          chan_ready,
  input  logic [scfp_pkg::CH_IDX_W-1:0] channel_index,
  input  logic [scfp_pkg::SUM_W-1:0]    channel_value,
  input  logic                          last_channel,
  output int                            error_count,
  output int                            pending
);

  localparam logic [scfp_pkg::POS_W-1:0] HUNT_POS = '0;
  localparam logic [scfp_pkg::POS_W-1:0] CMD_POS  = scfp_pkg::POS_W'(1);

  typedef struct packed {
    logic [scfp_pkg::CH_IDX_W-1:0] index;
    logic [scfp_pkg::SUM_W-1:0]    value;
    logic                          last;
  } chan_item_t;

  logic [scfp_pkg::POS_W-1:0]  frame_pos;
  logic [scfp_pkg::SUM_W-1:0]  running_sum;
  logic [scfp_pkg::BYTE_W-1:0] low_hold;
  logic [scfp_pkg::SUM_W-1:0]  channel_copy [scfp_pkg::STORE_DEPTH];
  chan_item_t                  due_channels [$];
  int                          mismatches = 0;

  // walks the frame state forward by one accepted byte
  task automatic absorb_byte(input logic [scfp_pkg::BYTE_W-1:0] b);
    chan_item_t item;
    if (frame_pos == HUNT_POS) begin
      if (b == scfp_pkg::LEN_BYTE) begin
        running_sum = scfp_pkg::SUM_INIT - scfp_pkg::SUM_W'(scfp_pkg::LEN_BYTE);
        frame_pos   = CMD_POS;
      end
    end else if (frame_pos == CMD_POS) begin
      // a wrong command byte is dropped, not taken as a new length byte
      if (b == scfp_pkg::CMD_BYTE) begin
        running_sum = running_sum - scfp_pkg::SUM_W'(scfp_pkg::CMD_BYTE);
        frame_pos   = scfp_pkg::POS_W'(2);
      end else begin
        frame_pos = HUNT_POS;
      end
    end else if (frame_pos < scfp_pkg::POS_W'(scfp_pkg::POS_CSUM_LO)) begin
      running_sum = running_sum - scfp_pkg::SUM_W'(b);
      if (!frame_pos[0]) begin
        low_hold = b;
      end else begin
        channel_copy[(frame_pos - scfp_pkg::POS_W'(2)) >> 1] = {b, low_hold};
      end
      frame_pos = frame_pos + scfp_pkg::POS_W'(1);
    end else if (frame_pos == scfp_pkg::POS_W'(scfp_pkg::POS_CSUM_LO)) begin
      low_hold  = b;
      frame_pos = scfp_pkg::POS_W'(scfp_pkg::POS_CSUM_HI);
    end else begin
      if ({b, low_hold} == running_sum) begin
        for (int k = 0; k < scfp_pkg::CHANNEL_COUNT; k++) begin
          item.index = scfp_pkg::CH_IDX_W'(k);
          item.value = channel_copy[k];
          item.last  = (k == scfp_pkg::CHANNEL_COUNT - 1);
          due_channels.push_back(item);
        end
      end
      frame_pos = HUNT_POS;
    end
  endtask

  always @(posedge clk) begin
    chan_item_t want;
    chan_item_t got;
    if (rst) begin
      frame_pos   = HUNT_POS;
      running_sum = scfp_pkg::SUM_INIT;
      low_hold    = '0;
      due_channels.delete();
    end else begin
      if (chan_valid && chan_ready) begin
        got = '{channel_index, channel_value, last_channel};
        if (due_channels.size() == 0) begin
          $display("%0t: unexpected channel item: index %0d value 0x%04h last %0b",
                   $realtime, got.index, got.value, got.last);
          mismatches++;
        end else begin
          want = due_channels.pop_front();
          if (got != want) begin
            $display("%0t: channel item mismatch: expected index %0d value 0x%04h last %0b",
                     $realtime, want.index, want.value, want.last);
            $display("%0t:                        actual   index %0d value 0x%04h last %0b",
                     $realtime, got.index, got.value, got.last);
            mismatches++;
          end
        end
      end
      if (byte_valid && byte_ready) begin
        absorb_byte(data_byte);
      end
    end
    pending     <= due_channels.size();
    error_count <= mismatches;
  end

endmodule

FILE: test/servo_channel_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_channel_frame_parser_tb
// Feeds the frame parser with serial bytes: a handful of hand-made frames and
// hunting cases, then a random mix of good frames, bad checksums, wrong
// command bytes, cut-short frames and line noise, with random gaps and
// stalls on both sides. A checker beside the parser predicts the channel items.
// ----------------------------------------------------------------------------
module servo_channel_frame_parser_tb;

  localparam int PAYLOAD_LEN = scfp_pkg::POS_CSUM_LO - 2;
  localparam int BYTE_TARGET = 330;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;

  logic clk = 1'b0;
  logic rst;

  scfp_byte_if byte_if ();
  scfp_chan_if chan_if ();

  int                          chk_errors;
  int                          chk_pending;
  logic [scfp_pkg::BYTE_W-1:0] payload [PAYLOAD_LEN];
  bit                          steady;
  bit                          hold_off_req;
  int                          sent_bytes;

  servo_channel_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .chan_out (chan_if)
  );

  scfp_channel_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_if.valid),
    .byte_ready    (byte_if.ready),
    .data_byte     (byte_if.data_byte),
    .chan_valid    (chan_if.valid),
    .chan_ready    (chan_if.ready),
    .channel_index (chan_if.channel_index),
    .channel_value (chan_if.channel_value),
    .last_channel  (chan_if.last_channel),
    .error_count   (chk_errors),
    .pending       (chk_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL servo_channel_frame_parser");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_serial_byte(input logic [scfp_pkg::BYTE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= value;
    do @(posedge clk); while (!byte_if.ready);
    sent_bytes++;
  endtask

  // whole frame from the payload array; a corrupted sum must be dropped
  task automatic send_frame(input bit bad_sum);
    logic [scfp_pkg::SUM_W-1:0] sum;
    sum = scfp_pkg::SUM_INIT - scfp_pkg::SUM_W'(scfp_pkg::LEN_BYTE)
          - scfp_pkg::SUM_W'(scfp_pkg::CMD_BYTE);
    for (int i = 0; i < PAYLOAD_LEN; i++) sum = sum - scfp_pkg::SUM_W'(payload[i]);
    if (bad_sum) sum = sum ^ scfp_pkg::SUM_W'($urandom_range(1, 65535));
    send_serial_byte(scfp_pkg::LEN_BYTE);
    send_serial_byte(scfp_pkg::CMD_BYTE);
    for (int i = 0; i < PAYLOAD_LEN; i++) send_serial_byte(payload[i]);
    send_serial_byte(sum[7:0]);
    send_serial_byte(sum[15:8]);
  endtask

  task automatic fill_random_payload();
    int r;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       payload[i] = 8'h00;
        1:       payload[i] = 8'hFF;
        2:       payload[i] = scfp_pkg::LEN_BYTE;
        3:       payload[i] = scfp_pkg::CMD_BYTE;
        default: payload[i] = scfp_pkg::BYTE_W'($urandom_range(0, 255));
      endcase
    end
  endtask

  // receiver side: random ready runs, plus one long hold-off with work queued
  initial begin
    int  run_left;
    int  r;
    bit  hold_off_done;
    chan_if.ready = 1'b0;
    run_left      = 0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done && chk_pending != 0) begin
        chan_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_done = 1'b1;
      end else if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          chan_if.ready <= 1'b1;
          run_left = $urandom_range(1, 24);
        end else if (r < 90) begin
          chan_if.ready <= 1'b0;
          run_left = $urandom_range(1, 3);
        end else begin
          chan_if.ready <= 1'b0;
          run_left = $urandom_range(8, 60);
        end
      end else begin
        run_left--;
      end
    end
  end

  initial begin
    int kind;
    int cut;
    rst               = 1'b1;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    steady            = 1'b0;
    hold_off_req      = 1'b0;
    sent_bytes        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hunting: stray bytes, a command byte with no length byte before it
    send_serial_byte(8'h00);
    send_serial_byte(8'hFF);
    send_serial_byte(scfp_pkg::CMD_BYTE);
    // wrong command byte
    send_serial_byte(scfp_pkg::LEN_BYTE);
    send_serial_byte(8'h41);
    // wrong command byte that is itself a length byte: no new frame starts
    send_serial_byte(scfp_pkg::LEN_BYTE);
    send_serial_byte(scfp_pkg::LEN_BYTE);
    send_serial_byte(scfp_pkg::CMD_BYTE);

    foreach (payload[i]) payload[i] = 8'hFF;
    send_frame(1'b0);
    foreach (payload[i]) payload[i] = 8'h00;
    steady = 1'b1;
    send_frame(1'b0);
    steady = 1'b0;
    foreach (payload[i]) payload[i] = scfp_pkg::BYTE_W'(i * 9 + 1);
    send_frame(1'b1);
    foreach (payload[i]) payload[i] = (i % 2 == 0) ? scfp_pkg::LEN_BYTE : scfp_pkg::CMD_BYTE;
    send_frame(1'b0);

    hold_off_req <= 1'b1;
    while (sent_bytes < BYTE_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      kind   = $urandom_range(0, 99);
      fill_random_payload();
      if (kind < 70) begin
        send_frame(1'b0);
      end else if (kind < 80) begin
        send_frame(1'b1);
      end else if (kind < 88) begin
        send_serial_byte(scfp_pkg::LEN_BYTE);
        if ($urandom_range(0, 2) == 0) send_serial_byte(scfp_pkg::LEN_BYTE);
        else send_serial_byte(scfp_pkg::BYTE_W'($urandom_range(0, 255)) & 8'hBF);
      end else if (kind < 94) begin
        // frame cut short; what follows lands in its payload
        cut = $urandom_range(1, PAYLOAD_LEN - 1);
        send_serial_byte(scfp_pkg::LEN_BYTE);
        send_serial_byte(scfp_pkg::CMD_BYTE);
        for (int i = 0; i < cut; i++) send_serial_byte(payload[i]);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_serial_byte(scfp_pkg::BYTE_W'($urandom_range(0, 255)));
        end
      end
    end

    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("PASS servo_channel_frame_parser");
    end else begin
      $display("FAIL servo_channel_frame_parser");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/scfp_pkg.sv
rtl/scfp_byte_if.sv
rtl/scfp_chan_if.sv
rtl/scfp_checksum.sv
rtl/servo_channel_frame_parser.sv
rtl/scfp_checker.sv
test/scfp_channel_checker.sv
test/servo_channel_frame_parser_tb.sv
